FILE: hw/rtl/fasta_nucleotide_filter_top_defines.svh
// Assertion macros for the FASTA nucleotide filter.
`ifndef FASTA_NUCLEOTIDE_FILTER_TOP_DEFINES_SVH
`define FASTA_NUCLEOTIDE_FILTER_TOP_DEFINES_SVH

// Implication checked in the same cycle.
`define FNF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("fnf assertion failed");

// Implication checked in the cycle after the antecedent.
`define FNF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("fnf assertion failed");

`endif

FILE: hw/rtl/fnf_pkg.sv
// Package for the FASTA nucleotide filter: widths, character codes, base decode.
package fnf_pkg;

  localparam int SEQ_INDEX_BITS = 16;
  localparam int POS_BITS       = 32;

  localparam int SEQ_OUT_BITS = 16;
  localparam int POS_OUT_BITS = 32;
  localparam int CNT_BITS     = 32;

  localparam int SEQ_WIDE_BITS = (SEQ_INDEX_BITS > SEQ_OUT_BITS) ? SEQ_INDEX_BITS : SEQ_OUT_BITS;
  localparam int POS_WIDE_BITS = (POS_BITS > POS_OUT_BITS) ? POS_BITS : POS_OUT_BITS;

  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_GT      = 8'h3E;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_C = 8'h43;
  localparam logic [7:0] CHAR_UPPER_G = 8'h47;
  localparam logic [7:0] CHAR_UPPER_T = 8'h54;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_C = 8'h63;
  localparam logic [7:0] CHAR_LOWER_G = 8'h67;
  localparam logic [7:0] CHAR_LOWER_T = 8'h74;

  typedef enum logic [1:0] {
    BASE_A = 2'd0,
    BASE_C = 2'd1,
    BASE_G = 2'd2,
    BASE_T = 2'd3
  } base_code_t;

  typedef struct packed {
    logic       is_base;
    logic       is_upper;
    base_code_t code;
  } base_info_t;

  function automatic base_info_t base_decode(input logic [7:0] c);
    base_info_t info;
    info.is_base  = 1'b1;
    info.is_upper = 1'b1;
    info.code     = BASE_A;
    case (c)
      CHAR_UPPER_A: info.code = BASE_A;
      CHAR_UPPER_C: info.code = BASE_C;
      CHAR_UPPER_G: info.code = BASE_G;
      CHAR_UPPER_T: info.code = BASE_T;
      CHAR_LOWER_A: begin info.code = BASE_A; info.is_upper = 1'b0; end
      CHAR_LOWER_C: begin info.code = BASE_C; info.is_upper = 1'b0; end
      CHAR_LOWER_G: begin info.code = BASE_G; info.is_upper = 1'b0; end
      CHAR_LOWER_T: begin info.code = BASE_T; info.is_upper = 1'b0; end
      default: begin
        info.is_base  = 1'b0;
        info.is_upper = 1'b0;
      end
    endcase
    return info;
  endfunction

endpackage

FILE: hw/rtl/fasta_nucleotide_filter_top.sv
// A base request appears on the result port in the cycle after it is accepted.
// Throughput: one text byte per cycle while in_stall is low, set by the per-byte counter update loop.
// The result register decouples the sides; input stalls only while a result is held.
// Reset (rst_n low, synchronous): parser at line start, no header seen, counters zero,
// budget register all ones, result register empty.
// Top level of the FASTA nucleotide filter.
`include "fasta_nucleotide_filter_top_defines.svh"

module fasta_nucleotide_filter_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [fnf_pkg::CNT_BITS-1:0]           cfg_wr_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [7:0]                             in_char_byte,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [1:0]                             out_base_code,
  output logic                                   out_is_upper,
  output logic [fnf_pkg::SEQ_OUT_BITS-1:0]       out_seq_number,
  output logic [fnf_pkg::POS_OUT_BITS-1:0]       out_seq_offset,
  output logic                                   out_run_start,
  output logic                                   out_format_error
);
  import fnf_pkg::*;

  logic                      max_total_bases_r;
  logic [CNT_BITS-1:0]       max_bases_r;
  logic                      at_line_start_r, at_line_start_nxt;
  logic                      in_header_r, in_header_nxt;
  logic                      header_seen_r, header_seen_nxt;
  logic                      error_reported_r, error_reported_nxt;
  logic [SEQ_INDEX_BITS-1:0] seq_counter_r, seq_counter_nxt;
  logic [POS_BITS-1:0]       pos_counter_r, pos_counter_nxt;
  logic                      prev_was_base_r, prev_was_base_nxt;
  logic [CNT_BITS-1:0]       emitted_total_r, emitted_total_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [1:0]                base_code_r, base_code_nxt;
  logic                      is_upper_r, is_upper_nxt;
  logic [SEQ_OUT_BITS-1:0]   seq_number_r, seq_number_nxt;
  logic [POS_OUT_BITS-1:0]   seq_offset_r, seq_offset_nxt;
  logic                      run_start_r, run_start_nxt;
  logic                      format_error_r, format_error_nxt;

  logic                      accept;
  logic                      emit;
  base_info_t                info;
  logic [SEQ_WIDE_BITS-1:0]  seq_wide;
  logic [POS_WIDE_BITS-1:0]  pos_wide;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign info     = base_decode(in_char_byte);
  assign seq_wide = SEQ_WIDE_BITS'(seq_counter_r);
  assign pos_wide = POS_WIDE_BITS'(pos_counter_r);

  // Parser state update for one accepted byte
  always_comb begin
    at_line_start_nxt  = at_line_start_r;
    in_header_nxt      = in_header_r;
    header_seen_nxt    = header_seen_r;
    error_reported_nxt = error_reported_r;
    seq_counter_nxt    = seq_counter_r;
    pos_counter_nxt    = pos_counter_r;
    prev_was_base_nxt  = prev_was_base_r;
    emitted_total_nxt  = emitted_total_r;
    emit               = 1'b0;
    base_code_nxt      = 2'd0;
    is_upper_nxt       = 1'b0;
    seq_number_nxt     = '0;
    seq_offset_nxt     = '0;
    run_start_nxt      = 1'b0;
    format_error_nxt   = 1'b0;
    if (accept) begin
      if (in_char_byte == CHAR_LF) begin
        at_line_start_nxt = 1'b1;
        in_header_nxt     = 1'b0;
      end else if (at_line_start_r && in_char_byte == CHAR_GT) begin
        at_line_start_nxt = 1'b0;
        in_header_nxt     = 1'b1;
        header_seen_nxt   = 1'b1;
        if (!header_seen_r) begin
          seq_counter_nxt = '0;
        end else if (seq_counter_r != '1) begin
          seq_counter_nxt = seq_counter_r + 1'b1;
        end
        pos_counter_nxt   = '0;
        prev_was_base_nxt = 1'b0;
      end else begin
        at_line_start_nxt = 1'b0;
        if (in_header_r) begin
          // rest of header line ignored
        end else if (!header_seen_r) begin
          if (!error_reported_r) begin
            error_reported_nxt = 1'b1;
            emit               = 1'b1;
            format_error_nxt   = 1'b1;
          end
        end else begin
          if (info.is_base) begin
            if (emitted_total_r < max_bases_r) begin
              emit              = 1'b1;
              emitted_total_nxt = emitted_total_r + 1'b1;
              base_code_nxt     = info.code;
              is_upper_nxt      = info.is_upper;
              seq_number_nxt    = (seq_wide > SEQ_WIDE_BITS'({SEQ_OUT_BITS{1'b1}})) ?
                                  '1 : seq_wide[SEQ_OUT_BITS-1:0];
              seq_offset_nxt    = (pos_wide > POS_WIDE_BITS'({POS_OUT_BITS{1'b1}})) ?
                                  '1 : pos_wide[POS_OUT_BITS-1:0];
              run_start_nxt     = ~prev_was_base_r;
            end
            prev_was_base_nxt = 1'b1;
          end else begin
            prev_was_base_nxt = 1'b0;
          end
          if (pos_counter_r != '1) begin
            pos_counter_nxt = pos_counter_r + 1'b1;
          end
        end
      end
    end
    out_valid_nxt = emit | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_total_bases_r <= 1'b0;
      max_bases_r       <= '1;
      at_line_start_r   <= 1'b1;
      in_header_r       <= 1'b0;
      header_seen_r     <= 1'b0;
      error_reported_r  <= 1'b0;
      seq_counter_r     <= '0;
      pos_counter_r     <= '0;
      prev_was_base_r   <= 1'b0;
      emitted_total_r   <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      max_total_bases_r <= max_total_bases_r | cfg_wr_en;
      if (cfg_wr_en) begin
        max_bases_r <= cfg_wr_data;
      end
      at_line_start_r  <= at_line_start_nxt;
      in_header_r      <= in_header_nxt;
      header_seen_r    <= header_seen_nxt;
      error_reported_r <= error_reported_nxt;
      seq_counter_r    <= seq_counter_nxt;
      pos_counter_r    <= pos_counter_nxt;
      prev_was_base_r  <= prev_was_base_nxt;
      emitted_total_r  <= emitted_total_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // Result payload, loaded only with a new request
  always_ff @(posedge clk) begin
    if (emit) begin
      base_code_r    <= base_code_nxt;
      is_upper_r     <= is_upper_nxt;
      seq_number_r   <= seq_number_nxt;
      seq_offset_r   <= seq_offset_nxt;
      run_start_r    <= run_start_nxt;
      format_error_r <= format_error_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_base_code    = base_code_r;
  assign out_is_upper     = is_upper_r;
  assign out_seq_number   = seq_number_r;
  assign out_seq_offset   = seq_offset_r;
  assign out_run_start    = run_start_r;
  assign out_format_error = format_error_r;

  `FNF_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall, out_valid_r)
  `FNF_ASSERT_NOW(a_err_flag_set, clk, rst_n, out_valid_r && format_error_r, error_reported_r)
  `FNF_ASSERT_NOW(a_base_after_header, clk, rst_n, out_valid_r && !format_error_r,
                  header_seen_r)
  `FNF_ASSERT_NEXT(a_lf_to_line_start, clk, rst_n, accept && in_char_byte == CHAR_LF,
                   at_line_start_r && !in_header_r)
  `FNF_ASSERT_NEXT(a_cfg_known, clk, rst_n, cfg_wr_en, max_total_bases_r)

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the FASTA nucleotide filter: directed and random text traffic.
module testbench;
  import fnf_pkg::*;

  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_BYTES  = 440;
  localparam int EXP_DEPTH    = 16;

  typedef struct {
    base_code_t                code;
    logic                      upper;
    logic [SEQ_OUT_BITS-1:0]   seq;
    logic [POS_OUT_BITS-1:0]   offset;
    logic                      run_start;
    logic                      fmt_err;
  } base_result_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [CNT_BITS-1:0]      cfg_wr_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [7:0]               in_char_byte = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               out_base_code;
  logic                     out_is_upper;
  logic [SEQ_OUT_BITS-1:0]  out_seq_number;
  logic [POS_OUT_BITS-1:0]  out_seq_offset;
  logic                     out_run_start;
  logic                     out_format_error;

  fasta_nucleotide_filter_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_base_code    (out_base_code),
    .out_is_upper     (out_is_upper),
    .out_seq_number   (out_seq_number),
    .out_seq_offset   (out_seq_offset),
    .out_run_start    (out_run_start),
    .out_format_error (out_format_error)
  );

  // Parser state mirrored from the block
  logic                    line_start = 1'b1;
  logic                    hdr_line = 1'b0;
  logic                    hdr_seen = 1'b0;
  logic                    err_done = 1'b0;
  logic                    last_was_base = 1'b0;
  logic [SEQ_INDEX_BITS-1:0] seq_idx = '0;
  logic [POS_BITS-1:0]     pos = '0;
  logic [CNT_BITS-1:0]     base_budget = '1;
  logic [CNT_BITS-1:0]     bases_sent = '0;

  // Expected results in order, kept as a small ring
  base_result_t exp_fifo[EXP_DEPTH];
  int  exp_wr = 0;
  int  exp_rd = 0;
  int  exp_count = 0;

  int  idle_pct = 0;
  int  stall_pct = 0;
  logic hold_rx = 1'b0;
  int  bytes_sent = 0;
  int  results_checked = 0;
  int  fmt_errs_seen = 0;
  int  budget_writes = 0;
  int  mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Timeout at %0t", $time);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void exp_put(input base_result_t r);
    if (exp_count == EXP_DEPTH) begin
      mismatches++;
      $display("%0t: too many outstanding results, expected at most %0d, actual %0d",
               $time, EXP_DEPTH, exp_count + 1);
      return;
    end
    exp_fifo[exp_wr] = r;
    exp_wr = (exp_wr + 1) % EXP_DEPTH;
    exp_count++;
  endfunction

  function automatic base_result_t exp_take();
    base_result_t r;
    r = exp_fifo[exp_rd];
    exp_rd = (exp_rd + 1) % EXP_DEPTH;
    exp_count--;
    return r;
  endfunction

  // Work out what one accepted text byte yields
  task automatic parse_byte(input logic [7:0] c);
    base_result_t r;
    logic         is_base;
    if (c == CHAR_LF) begin
      line_start = 1'b1;
      hdr_line   = 1'b0;
      return;
    end
    if (line_start && c == CHAR_GT) begin
      line_start = 1'b0;
      hdr_line   = 1'b1;
      if (hdr_seen) begin
        if (seq_idx != '1) seq_idx++;
      end else begin
        hdr_seen = 1'b1;
        seq_idx  = '0;
      end
      pos           = '0;
      last_was_base = 1'b0;
      return;
    end
    line_start = 1'b0;
    if (hdr_line) return;
    if (!hdr_seen) begin
      if (!err_done) begin
        err_done    = 1'b1;
        r.code      = BASE_A;
        r.upper     = 1'b0;
        r.seq       = '0;
        r.offset    = '0;
        r.run_start = 1'b0;
        r.fmt_err   = 1'b1;
        exp_put(r);
      end
      return;
    end
    is_base = 1'b1;
    r.code  = BASE_A;
    case (c)
      CHAR_UPPER_A, CHAR_LOWER_A: r.code = BASE_A;
      CHAR_UPPER_C, CHAR_LOWER_C: r.code = BASE_C;
      CHAR_UPPER_G, CHAR_LOWER_G: r.code = BASE_G;
      CHAR_UPPER_T, CHAR_LOWER_T: r.code = BASE_T;
      default: is_base = 1'b0;
    endcase
    if (is_base) begin
      if (bases_sent < base_budget) begin
        r.upper     = ~c[5];  // ASCII case bit
        r.seq       = seq_idx;
        r.offset    = pos;
        r.run_start = ~last_was_base;
        r.fmt_err   = 1'b0;
        exp_put(r);
        bases_sent++;
      end
      last_was_base = 1'b1;
    end else begin
      last_was_base = 1'b0;
    end
    if (pos != '1) pos++;
  endtask

  task automatic send_byte(input logic [7:0] c);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_byte <= c;
    do @(posedge clk); while (in_stall);
    parse_byte(c);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (exp_count != 0);
    // requests that give nothing may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_base_budget(input logic [CNT_BITS-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    base_budget = value;
    budget_writes++;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] rand_base_char();
    case ($urandom_range(7))
      0: return CHAR_UPPER_A;
      1: return CHAR_UPPER_C;
      2: return CHAR_UPPER_G;
      3: return CHAR_UPPER_T;
      4: return CHAR_LOWER_A;
      5: return CHAR_LOWER_C;
      6: return CHAR_LOWER_G;
      default: return CHAR_LOWER_T;
    endcase
  endfunction

  function automatic logic [7:0] rand_non_lf();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if (c == CHAR_LF) c = 8'($urandom_range(11, 255));
    return c;
  endfunction

  task automatic send_random_record();
    int n_lines;
    // some noise: unstructured bytes, newlines and stray markers included
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(255)));
      return;
    end
    send_byte(CHAR_GT);
    repeat ($urandom_range(0, 8)) send_byte(rand_non_lf());
    send_byte(CHAR_LF);
    n_lines = $urandom_range(1, 4);
    repeat (n_lines) begin
      repeat ($urandom_range(0, 24))
        send_byte(($urandom_range(99) < 85) ? rand_base_char() : rand_non_lf());
      send_byte(CHAR_LF);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    base_result_t want;
    if (exp_count == 0) begin
      mismatches++;
      $display("%0t: unexpected result, expected none, actual base %0d seq %0d off %0d err %0b",
               $time, out_base_code, out_seq_number, out_seq_offset, out_format_error);
      return;
    end
    want = exp_take();
    results_checked++;
    if (out_format_error) fmt_errs_seen++;
    compare_field("base_code", 32'(want.code), 32'(out_base_code));
    compare_field("is_upper", 32'(want.upper), 32'(out_is_upper));
    compare_field("seq_number", 32'(want.seq), 32'(out_seq_number));
    compare_field("seq_offset", 32'(want.offset), 32'(out_seq_offset));
    compare_field("run_start", 32'(want.run_start), 32'(out_run_start));
    compare_field("format_error", 32'(want.fmt_err), 32'(out_format_error));
  endtask

  // Result side: check accepted results, then choose next cycle's stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
    if (hold_rx) out_stall <= 1'b1;
    else out_stall <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
  end

  task automatic test_directed();
    idle_pct = 0;
    stall_pct <= 0;
    // bytes before any header, header text, all eight bases, extreme bytes,
    // a mid-line marker, CR, an empty line, a run across a line break
    send_text("xA\n>s\nACGgt");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text(">\r\n\nTa\nc\n>\ng");
    drain_results();
  endtask

  task automatic test_budget();
    write_base_budget('0);
    send_text("\n>b\nACGT\n");
    write_base_budget(bases_sent + 3);
    send_text("acgtAC\n");
    write_base_budget('1);
    send_text("GT\n");
    drain_results();
  endtask

  task automatic test_receiver_hold();
    idle_pct = 0;
    stall_pct <= 0;
    fork
      begin
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
      end
    join_none
    send_text(">p\n");
    repeat (60) send_byte(rand_base_char());
    send_byte(CHAR_LF);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int in_idle[4]  = '{0, 87, 0, 11};
    int out_idle[4] = '{0, 0, 87, 11};
    int start;
    for (int p = 0; p < 4; p++) begin
      case ($urandom_range(3))
        0: write_base_budget(bases_sent + $urandom_range(0, 40));
        1: write_base_budget($urandom);
        default: write_base_budget('1);
      endcase
      idle_pct = in_idle[p];
      stall_pct <= out_idle[p];
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) send_random_record();
    end
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_budget();
    test_receiver_hold();
    test_random_traffic();
    drain_results();
    $display("Run covered %0d text bytes and %0d checked results (%0d format errors),",
             bytes_sent, results_checked, fmt_errs_seen);
    $display("with %0d budget writes, a long receiver hold and four idling mixes.",
             budget_writes);
    if (mismatches == 0 && exp_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: fasta_nucleotide_filter_top.f
+incdir+hw/rtl
hw/rtl/fnf_pkg.sv
hw/rtl/fasta_nucleotide_filter_top.sv
verif/testbench.sv
